// ----- rtl/fbv_pkg.sv -----
// fbv_pkg: shared types and constants of the frustum box visibility test
// box and plane formats, register file layout and reset values
// no dependencies
`default_nettype none

package fbv_pkg;

  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int NUM_PLANES = 6;
  localparam int CW         = 32;          // Q16.16 coordinate or matrix entry
  localparam int NW         = CW + 1;      // plane coefficient, Q17.16
  localparam int PW         = NW + CW;     // one coefficient times one coordinate
  localparam int SW         = PW + 1;      // sum of two terms
  localparam int TW         = SW + 1;      // full distance
  localparam int DSHIFT     = 16;          // d is scaled by 2^16 and sign-extended into Q34.32

  typedef logic [2:0][CW-1:0] vec3_t;

  // lo[0] sits in the lowest bits, matching the input tdata packing
  typedef struct packed {
    vec3_t hi;
    vec3_t lo;
  } box_t;

  typedef struct packed {
    logic [2:0][NW-1:0] n;
    logic [NW-1:0]      d;
  } plane_t;

  typedef plane_t [NUM_PLANES-1:0] plane_set_t;

  typedef logic [NUM_PLANES-1:0][2:0][CW-1:0] corner_set_t;
  typedef logic [NUM_PLANES-1:0][2:0][PW-1:0] prod_set_t;
  typedef logic [NUM_REGS-1:0][63:0]          reg_file_t;

  // identity matrix
  localparam reg_file_t REG_RESET = {
    64'h0001_0000_0000_0000,  // r3 c23
    64'h0000_0000_0000_0000,  // r3 c01
    64'h0000_0000_0001_0000,  // r2 c23
    64'h0000_0000_0000_0000,  // r2 c01
    64'h0000_0000_0000_0000,  // r1 c23
    64'h0001_0000_0000_0000,  // r1 c01
    64'h0000_0000_0000_0000,  // r0 c23
    64'h0000_0000_0001_0000   // r0 c01
  };

endpackage

`default_nettype wire

// ----- rtl/frustum_box_visibility_test_unit.sv -----
// frustum_box_visibility_test_unit: top level of the frustum box culling test
// instantiates fbv_regs, fbv_mul and fbv_sum; depends on fbv_pkg
// The unit takes one axis-aligned box per cycle while the output does not
// stall and answers visible = 0 when the box lies fully outside one of the
// six clip planes of the configured view-projection matrix, otherwise 1. Its
// answer passes through the four pipeline registers in order: corner select,
// the 18 coefficient-by-coordinate multipliers, the pair adders, and the
// final add with the output register. Results leave in input order; stalls
// on the output back up through the stages and fill bubbles. The user must
// write the matrix through the register port only while no box is in flight;
// the block does not enforce it. After reset the matrix holds the identity.
`default_nettype none

module frustum_box_visibility_test_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z, 32 bits each from bit 0
  input  wire logic [191:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // visible in bit 0, bits 7:1 zero
  output logic [7:0]        out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [5:0]   cfg_paddr,
  input  wire logic [63:0]  cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready
);

  fbv_pkg::plane_set_t planes;
  fbv_pkg::prod_set_t  prods;
  fbv_pkg::box_t       box;
  logic                mul_valid;
  logic                sum_ready;
  logic                visible;

  assign box = fbv_pkg::box_t'(in_tdata);

  fbv_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .planes      (planes)
  );

  fbv_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .planes    (planes),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .box       (box),
    .out_valid (mul_valid),
    .out_ready (sum_ready),
    .prods     (prods)
  );

  fbv_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .planes    (planes),
    .in_valid  (mul_valid),
    .in_ready  (sum_ready),
    .prods     (prods),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .visible   (visible)
  );

  assign out_tdata = {7'd0, visible};

endmodule

`default_nettype wire

// ----- rtl/fbv_regs.sv -----
// fbv_regs: configuration register file with its APB-style write/read port
// derives the six clip planes from the stored matrix
// depends on fbv_pkg
`default_nettype none

module fbv_regs (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [5:0]          cfg_paddr,
  input  wire logic [63:0]         cfg_pwdata,
  output logic      [63:0]         cfg_prdata,
  output logic                     cfg_pready,
  output fbv_pkg::plane_set_t      planes
);

  fbv_pkg::reg_file_t                regs_r;
  logic [fbv_pkg::REG_IDX_W-1:0]     idx;
  logic                              wr_en;

  function automatic logic [fbv_pkg::NW-1:0] entry(
    input fbv_pkg::reg_file_t rf, input logic [1:0] r, input logic [1:0] c);
    logic [63:0] w;
    w = rf[{r, c[1]}];
    return c[0] ? {w[63], w[63:32]} : {w[31], w[31:0]};
  endfunction

  function automatic fbv_pkg::plane_t plane_of(
    input fbv_pkg::reg_file_t rf, input logic [1:0] k, input logic s);
    fbv_pkg::plane_t             pl;
    logic [fbv_pkg::NW-1:0]      a3;
    logic [fbv_pkg::NW-1:0]      ak;
    for (int c = 0; c < 4; c++) begin
      a3 = entry(rf, 2'd3, 2'(c));
      ak = entry(rf, k, 2'(c));
      if (c == 3) begin
        pl.d = s ? (a3 - ak) : (a3 + ak);
      end else begin
        pl.n[c] = s ? (a3 - ak) : (a3 + ak);
      end
    end
    return pl;
  endfunction

  assign idx        = cfg_paddr[5:3];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = regs_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= fbv_pkg::REG_RESET;
    end else if (wr_en) begin
      regs_r[idx] <= cfg_pwdata;
    end
  end

  // plane 2k is row3 + rowk, plane 2k+1 is row3 - rowk
  for (genvar p = 0; p < fbv_pkg::NUM_PLANES; p++) begin : g_plane
    assign planes[p] = plane_of(regs_r, 2'(p >> 1), 1'(p & 1));
  end

endmodule

`default_nettype wire

// ----- rtl/fbv_mul.sv -----
// fbv_mul: corner selection stage and multiply stage of the box test pipeline
// picks the far corner per plane, then forms the 18 coefficient products
// depends on fbv_pkg
`default_nettype none

module fbv_mul (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fbv_pkg::plane_set_t planes,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire fbv_pkg::box_t       box,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output fbv_pkg::prod_set_t       prods
);

  logic                     v1_r;
  logic                     v2_r;
  logic                     rdy1;
  logic                     rdy2;
  fbv_pkg::corner_set_t     corner_r;
  fbv_pkg::corner_set_t     corner_nxt;
  fbv_pkg::prod_set_t       prod_r;
  fbv_pkg::prod_set_t       prod_nxt;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    for (int p = 0; p < fbv_pkg::NUM_PLANES; p++) begin
      for (int c = 0; c < 3; c++) begin
        // far corner: max where the normal component is positive
        corner_nxt[p][c] = (!planes[p].n[c][fbv_pkg::NW-1] && (|planes[p].n[c]))
                           ? box.hi[c] : box.lo[c];
        prod_nxt[p][c]   = fbv_pkg::PW'($signed(planes[p].n[c]))
                         * fbv_pkg::PW'($signed(corner_r[p][c]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      corner_r <= corner_nxt;
    end
    if (v1_r && rdy2) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_valid = v2_r;
  assign prods     = prod_r;

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !out_ready |=> v2_r && $stable(prod_r))
    else $error("product stage changed while stalled");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !rdy2 |=> v1_r && $stable(corner_r))
    else $error("corner stage changed while stalled");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted box did not enter corner stage");

endmodule

`default_nettype wire

// ----- rtl/fbv_sum.sv -----
// fbv_sum: distance accumulation stages and output register of the box test
// adds the products and scaled plane offset, then ands the six sign checks
// depends on fbv_pkg
`default_nettype none

module fbv_sum (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fbv_pkg::plane_set_t planes,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire fbv_pkg::prod_set_t  prods,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     visible
);

  logic                                       v3_r;
  logic                                       v4_r;
  logic                                       rdy3;
  logic                                       rdy4;
  logic [fbv_pkg::NUM_PLANES-1:0][fbv_pkg::SW-1:0] sa_r;
  logic [fbv_pkg::NUM_PLANES-1:0][fbv_pkg::SW-1:0] sb_r;
  logic [fbv_pkg::NUM_PLANES-1:0][fbv_pkg::SW-1:0] sa_nxt;
  logic [fbv_pkg::NUM_PLANES-1:0][fbv_pkg::SW-1:0] sb_nxt;
  logic [fbv_pkg::NUM_PLANES-1:0][fbv_pkg::TW-1:0] tot;
  logic                                       vis_r;
  logic                                       vis_nxt;

  localparam int PX = fbv_pkg::PW - 1;
  localparam int DX = fbv_pkg::SW - fbv_pkg::NW - fbv_pkg::DSHIFT;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign in_ready = rdy3;

  always_comb begin
    vis_nxt = 1'b1;
    for (int p = 0; p < fbv_pkg::NUM_PLANES; p++) begin
      sa_nxt[p] = {prods[p][0][PX], prods[p][0]} + {prods[p][1][PX], prods[p][1]};
      sb_nxt[p] = {prods[p][2][PX], prods[p][2]}
                + {{DX{planes[p].d[fbv_pkg::NW-1]}}, planes[p].d,
                   {fbv_pkg::DSHIFT{1'b0}}};
      tot[p]    = {sa_r[p][fbv_pkg::SW-1], sa_r[p]} + {sb_r[p][fbv_pkg::SW-1], sb_r[p]};
      // negative distance on any plane culls the box
      if (tot[p][fbv_pkg::TW-1]) begin
        vis_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy3) begin
        v3_r <= in_valid;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy3) begin
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
    end
    if (v3_r && rdy4) begin
      vis_r <= vis_nxt;
    end
  end

  assign out_valid = v4_r;
  assign visible   = vis_r;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// testbench for frustum_box_visibility_test_unit: random and directed boxes under
// several view-projection matrices, checked against a scoreboard with its own culling math
// depends on fbv_pkg and the rtl of the unit
`timescale 1ns / 100ps

module testbench;

  localparam int ONE             = 65536;
  localparam int HALF            = ONE / 2;
  localparam int ITEMS_PER_PHASE = 173;
  localparam int DRAIN_CYCLES    = 16;
  localparam int IDLE_LIMIT      = 3000;
  localparam int MAX_PRINTS      = 50;

  typedef enum int {
    MAT_IDENTITY,
    MAT_ZERO,
    MAT_MAX,
    MAT_MIN,
    MAT_RANDOM,
    MAT_PERSPECTIVE
  } mat_kind_t;

  typedef struct {
    fbv_pkg::box_t box;
    bit            visible;
  } verdict_t;

  class cull_scoreboard;
    logic [63:0] matrix_regs [fbv_pkg::NUM_REGS];
    verdict_t    pending_verdicts [$];
    int          n_checked;
    int          n_visible;
    int          n_culled;
    int          n_errors;

    function new();
      for (int i = 0; i < fbv_pkg::NUM_REGS; i++) matrix_regs[i] = fbv_pkg::REG_RESET[i];
    endfunction

    function void write_reg(int idx, logic [63:0] value);
      matrix_regs[idx] = value;
    endfunction

    function logic signed [31:0] entry(int r, int c);
      logic [63:0] w;
      w = matrix_regs[2 * r + c / 2];
      return (c % 2) ? w[63:32] : w[31:0];
    endfunction

    // six planes row3 +/- rows 0..2, positive vertex per plane, exact arithmetic
    function bit box_visible(fbv_pkg::box_t b);
      logic signed [127:0] plane_dist;
      logic signed [127:0] n;
      logic signed [127:0] p;
      bit vis;
      vis = 1'b1;
      for (int k = 0; k < 3; k++) begin
        for (int s = 0; s < 2; s++) begin
          n = (s == 0) ? (entry(3, 3) + entry(k, 3)) : (entry(3, 3) - entry(k, 3));
          plane_dist = n * 65536;
          for (int c = 0; c < 3; c++) begin
            n = (s == 0) ? (entry(3, c) + entry(k, c)) : (entry(3, c) - entry(k, c));
            p = (n > 0) ? $signed(b.hi[c]) : $signed(b.lo[c]);
            plane_dist = plane_dist + n * p;
          end
          if (plane_dist < 0) vis = 1'b0;
        end
      end
      return vis;
    endfunction

    function void note_box(fbv_pkg::box_t b);
      verdict_t v;
      v.box = b;
      v.visible = box_visible(b);
      pending_verdicts.push_back(v);
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    task report(string msg);
      if (n_errors < MAX_PRINTS) $display("mismatch: %s", msg);
      n_errors++;
    endtask

    task check_verdict(logic [7:0] data);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("result 0x%02h with no box waiting", data));
        return;
      end
      v = pending_verdicts.pop_front();
      if (data !== {7'd0, v.visible})
        report($sformatf("transaction %0d box %h: got 0x%02h, want visible=%0b",
                         n_checked, v.box, data, v.visible));
      n_checked++;
      if (v.visible) n_visible++;
      else n_culled++;
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [5:0]   cfg_paddr = '0;
  logic [63:0]  cfg_pwdata = '0;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  cull_scoreboard sb;
  int n_boxes = 0;
  int n_settings = 1;
  int burst_left = 0;
  int rdy_hold = 0;
  int rdy_pick;
  int idle_cycles = 0;

  mat_kind_t phase_plan [9] = '{MAT_ZERO, MAT_MAX, MAT_MIN, MAT_PERSPECTIVE, MAT_RANDOM,
                                MAT_RANDOM, MAT_PERSPECTIVE, MAT_IDENTITY, MAT_RANDOM};

  frustum_box_visibility_test_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // receiver back-pressure: mostly short stalls, a few long ones, some long ready runs
  always @(negedge clk) begin
    if (rdy_hold > 0) begin
      rdy_hold--;
    end else begin
      rdy_pick = $urandom_range(0, 99);
      if (rdy_pick < 55) begin
        out_tready <= 1'b1;
        rdy_hold = $urandom_range(0, 20);
      end else if (rdy_pick < 62) begin
        out_tready <= 1'b1;
        rdy_hold = $urandom_range(40, 150);
      end else if (rdy_pick < 90) begin
        out_tready <= 1'b0;
        rdy_hold = $urandom_range(0, 2);
      end else if (rdy_pick < 98) begin
        out_tready <= 1'b0;
        rdy_hold = $urandom_range(3, 10);
      end else begin
        out_tready <= 1'b0;
        rdy_hold = $urandom_range(20, 60);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_verdict(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  function automatic int next_gap();
    int pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (pick < 65) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [31:0] scaled_rand(int lo_sh, int hi_sh);
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(lo_sh, hi_sh);
  endfunction

  function automatic logic [31:0] extreme_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic fbv_pkg::box_t make_box(logic [31:0] lx, logic [31:0] ly,
                                             logic [31:0] lz, logic [31:0] hx,
                                             logic [31:0] hy, logic [31:0] hz);
    fbv_pkg::box_t b;
    b.lo[0] = lx;
    b.lo[1] = ly;
    b.lo[2] = lz;
    b.hi[0] = hx;
    b.hi[1] = hy;
    b.hi[2] = hz;
    return b;
  endfunction

  // mostly well-formed boxes around a center at a random scale, some raw noise
  function automatic fbv_pkg::box_t rand_box();
    fbv_pkg::box_t b;
    int mode;
    int sh;
    logic [31:0] c;
    logic [31:0] e;
    mode = $urandom_range(0, 99);
    sh = $urandom_range(0, 24);
    for (int i = 0; i < 3; i++) begin
      if (mode < 10) begin
        b.lo[i] = $urandom;
        b.hi[i] = $urandom;
      end else if (mode < 16) begin
        b.lo[i] = extreme_value();
        b.hi[i] = extreme_value();
      end else begin
        c = scaled_rand(sh, sh + 6);
        e = $urandom >> $urandom_range(sh + 1, 31);
        b.lo[i] = c - e;
        b.hi[i] = c + e;
      end
    end
    return b;
  endfunction

  task automatic send_box(input fbv_pkg::box_t b);
    int gap;
    gap = next_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_box(b);
    n_boxes++;
  endtask

  task automatic cfg_write(input int idx, input logic [63:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 6'(idx * 8);
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_matrix(input mat_kind_t kind);
    logic [31:0] m [4][4];
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        case (kind)
          MAT_IDENTITY: m[r][c] = (r == c) ? ONE : 0;
          MAT_MAX:      m[r][c] = 32'h7fff_ffff;
          MAT_MIN:      m[r][c] = 32'h8000_0000;
          MAT_RANDOM: begin
            case ($urandom_range(0, 9))
              0: m[r][c] = 32'h0000_0000;
              1: m[r][c] = 32'h8000_0000;
              2: m[r][c] = 32'h7fff_ffff;
              default: m[r][c] = scaled_rand(0, 20);
            endcase
          end
          default:      m[r][c] = 32'h0000_0000;
        endcase
      end
    end
    if (kind == MAT_PERSPECTIVE) begin
      m[0][0] = $urandom_range(HALF, 4 * ONE);
      m[1][1] = $urandom_range(HALF, 4 * ONE);
      m[2][2] = 32'd0 - $urandom_range(ONE, 2 * ONE);
      m[2][3] = 32'd0 - $urandom_range(ONE, 20 * ONE);
      m[3][2] = 32'd0 - ONE;
      m[0][3] = scaled_rand(14, 20);
      m[1][3] = scaled_rand(14, 20);
    end
    for (int i = 0; i < fbv_pkg::NUM_REGS; i++)
      cfg_write(i, {m[i / 2][2 * (i % 2) + 1], m[i / 2][2 * (i % 2)]});
  endtask

  initial begin
    sb = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // identity matrix from reset: unit cube frustum
    send_box(make_box(-HALF, -HALF, -HALF, HALF, HALF, HALF));
    send_box(make_box(ONE, 0, 0, 2 * ONE, HALF, HALF));
    send_box(make_box(ONE + 1, 0, 0, 2 * ONE, HALF, HALF));
    send_box(make_box(-2 * ONE, 0, 0, -ONE - 1, HALF, HALF));
    send_box(make_box(0, ONE + 1, 0, HALF, 2 * ONE, HALF));
    send_box(make_box(0, -2 * ONE, 0, HALF, -ONE - 1, HALF));
    send_box(make_box(0, 0, ONE + 1, HALF, HALF, 2 * ONE));
    send_box(make_box(0, 0, -2 * ONE, HALF, HALF, -ONE - 1));
    send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_box(make_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_box(make_box(HALF, HALF, HALF, -HALF, -HALF, -HALF));
    send_box(make_box(3 * ONE, 0, 0, 2 * ONE, HALF, HALF));
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(ONE, ONE, ONE, ONE, ONE, ONE));
    send_box(make_box(-ONE, -ONE, -ONE, -ONE, -ONE, -ONE));
    send_box(make_box(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                      32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555));
    send_box(make_box(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                      32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa));
    send_box(make_box(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                      32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    repeat (ITEMS_PER_PHASE) send_box(rand_box());

    foreach (phase_plan[ph]) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk);
      set_matrix(phase_plan[ph]);
      n_settings++;
      repeat (ITEMS_PER_PHASE) send_box(rand_box());
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("ran %0d boxes under %0d matrix settings: %0d visible, %0d culled",
             n_boxes, n_settings, sb.n_visible, sb.n_culled);
    $display("%0d results checked, %0d mismatches", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
